@@ sv/gbhs_pkg.sv @@
// Package for the Gaussian bump height sum: field widths, bump constants
// and the exp(-k/4) table used by the interpolating exponential.
// No dependencies.
`default_nettype none

package gbhs_pkg;

  localparam int COORD_W     = 16;
  localparam int OUT_W       = 16;
  localparam int DIFF_W      = 18;
  localparam int SQ_W        = 32;
  localparam int INV_W       = 21;
  localparam int PROD_W      = SQ_W + INV_W;
  localparam int T_SHIFT     = 24;
  localparam int T_W         = 20;
  localparam int FRAC_W      = 14;
  localparam int EXP_W       = 17;
  localparam int EXP_DEPTH   = 65;
  localparam int EXP_IDX_W   = $clog2(EXP_DEPTH);
  localparam int H_W         = 16;
  localparam int TERM_W      = H_W + EXP_W + 1;
  localparam int ROUND_SHIFT = 16;
  localparam int LATENCY     = 7;
  localparam int BUMP_MAX    = 4;
  localparam int NUM_BUMPS_DEF = 4;

  localparam logic signed [DIFF_W-1:0] CX [BUMP_MAX] =
    '{-18'sd2560, 18'sd1280, -18'sd768, 18'sd1536};
  localparam logic signed [DIFF_W-1:0] CY [BUMP_MAX] =
    '{-18'sd2560, 18'sd1280, 18'sd1024, 18'sd1024};
  localparam logic signed [H_W-1:0] H [BUMP_MAX] =
    '{16'sd12288, -16'sd6144, 16'sd4096, 16'sd8192};
  localparam logic [INV_W-1:0] INV [BUMP_MAX] =
    '{21'd167772, 21'd1864135, 21'd1048576, 21'd1048576};

  localparam logic [EXP_W-1:0] EXP_TAB [EXP_DEPTH] = '{
    17'd65536, 17'd51039, 17'd39750, 17'd30957, 17'd24109, 17'd18776, 17'd14623,
    17'd11388, 17'd8869, 17'd6907, 17'd5380, 17'd4190, 17'd3263, 17'd2541,
    17'd1979, 17'd1541, 17'd1200, 17'd935, 17'd728, 17'd567, 17'd442, 17'd344,
    17'd268, 17'd209, 17'd162, 17'd127, 17'd99, 17'd77, 17'd60, 17'd47, 17'd36,
    17'd28, 17'd22, 17'd17, 17'd13, 17'd10, 17'd8, 17'd6, 17'd5, 17'd4, 17'd3,
    17'd2, 17'd2, 17'd1, 17'd1, 17'd1, 17'd1, 17'd1, 17'd0, 17'd0, 17'd0, 17'd0,
    17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0,
    17'd0, 17'd0, 17'd0
  };

endpackage

`default_nettype wire

@@ sv/gaussian_bump_height_sum_top.sv @@
// Stages in order: squares, d2, t and far, table samples, e, term, height.
// Throughput: one item per cycle; the seven register stages each hold one
// multiplier, one table read or one wide add, and busy stays low.
// Reset clears the valid bits of every stage, so no result is shown after reset.
// Top level of the Gaussian bump height sum; depends on gbhs_pkg.
`default_nettype none

module gaussian_bump_height_sum_top
  import gbhs_pkg::*;
#(
  parameter int NUM_BUMPS = NUM_BUMPS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic signed [COORD_W-1:0] pos_x,
  input  wire logic signed [COORD_W-1:0] pos_y,
  output logic                           done,
  output logic signed [OUT_W-1:0]        height
);

  localparam int SUM_W = TERM_W + $clog2(NUM_BUMPS) + 1;
  localparam int R_W   = SUM_W - ROUND_SHIFT;

  logic [LATENCY-1:0] vld;

  logic [SQ_W-1:0]              sq_x [NUM_BUMPS];
  logic [SQ_W-1:0]              sq_y [NUM_BUMPS];
  logic [SQ_W-1:0]              d2   [NUM_BUMPS];
  logic [T_W-1:0]               t    [NUM_BUMPS];
  logic                         far  [NUM_BUMPS];
  logic [EXP_W-1:0]             hi   [NUM_BUMPS];
  logic [EXP_W-1:0]             diff [NUM_BUMPS];
  logic [FRAC_W-1:0]            frac [NUM_BUMPS];
  logic [EXP_W-1:0]             e    [NUM_BUMPS];
  logic signed [TERM_W-1:0]     term [NUM_BUMPS];

  logic signed [SUM_W-1:0] sum;
  logic signed [R_W-1:0]   r;
  logic signed [OUT_W-1:0] height_next;

  assign busy = 1'b0;
  assign done = vld[LATENCY-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LATENCY-2:0], start & ~busy};
    end
  end

  for (genvar b = 0; b < NUM_BUMPS; b++) begin : gen_bump
    logic signed [DIFF_W-1:0]   dx;
    logic signed [DIFF_W-1:0]   dy;
    logic signed [2*DIFF_W-1:0] px;
    logic signed [2*DIFF_W-1:0] py;
    logic [PROD_W-1:0]          prod;
    logic [EXP_IDX_W-1:0]       k;
    logic [EXP_IDX_W-1:0]       k1;
    logic [EXP_W-1:0]           hi_tab;
    logic [EXP_W-1:0]           lo_tab;
    logic [EXP_W+FRAC_W:0]      mix;

    always_comb begin
      dx     = DIFF_W'(pos_x) - CX[b];
      dy     = DIFF_W'(pos_y) - CY[b];
      px     = dx * dx;
      py     = dy * dy;
      prod   = d2[b] * PROD_W'(INV[b]);
      k      = EXP_IDX_W'(t[b][T_W-1:FRAC_W]);
      k1     = k + EXP_IDX_W'(1);
      hi_tab = EXP_TAB[k];
      lo_tab = EXP_TAB[k1];
      mix    = (EXP_W+FRAC_W+1)'(diff[b]) * (EXP_W+FRAC_W+1)'(frac[b])
             + (EXP_W+FRAC_W+1)'(1 << (FRAC_W - 1));
    end

    always_ff @(posedge clk) begin
      sq_x[b] <= px[SQ_W-1:0];
      sq_y[b] <= py[SQ_W-1:0];
      d2[b]   <= sq_x[b] + sq_y[b];
      t[b]    <= prod[T_SHIFT+T_W-1:T_SHIFT];
      far[b]  <= |prod[PROD_W-1:T_SHIFT+T_W];
      hi[b]   <= far[b] ? '0 : hi_tab;
      diff[b] <= far[b] ? '0 : hi_tab - lo_tab;
      frac[b] <= t[b][FRAC_W-1:0];
      e[b]    <= hi[b] - mix[EXP_W+FRAC_W-1:FRAC_W];
      term[b] <= H[b] * $signed({1'b0, e[b]});
    end
  end

  always_comb begin
    sum = SUM_W'(1 << (ROUND_SHIFT - 1));
    for (int b = 0; b < NUM_BUMPS; b++) begin
      sum = sum + SUM_W'(term[b]);
    end
    r = R_W'(sum >>> ROUND_SHIFT);
    if (r[R_W-1:OUT_W-1] == '0 || r[R_W-1:OUT_W-1] == '1) begin
      height_next = r[OUT_W-1:0];
    end else if (r[R_W-1]) begin
      height_next = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      height_next = {1'b0, {(OUT_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    height <= height_next;
  end

`ifndef NO_ASSERTIONS
  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LATENCY))
    else $error("Result strobe without an item accepted seven cycles earlier.");

  a_reset_no_done: assert property (@(posedge clk)
    rst |=> !done)
    else $error("Result strobe right after reset.");

  a_interp_bounded: assert property (@(posedge clk) disable iff (rst)
    vld[3] |=> e[0] <= $past(hi[0]))
    else $error("Interpolated exponential above its table sample.");

  a_first_term_sign: assert property (@(posedge clk) disable iff (rst)
    vld[5] |-> !term[0][TERM_W-1])
    else $error("Term of a positive bump came out negative.");
`endif

endmodule

`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for gaussian_bump_height_sum_top, which sums four Gaussian
// bumps at a Q8.8 point. It predicts each height in fixed point and checks every result.
// Depends on gbhs_pkg and the top level of the block.

module tb;
  import gbhs_pkg::*;

  localparam int NB = 4;
  localparam int PIPE_DEPTH = 7;
  localparam int RANDOM_POINTS = 1300;

  localparam int BUMP_CX [4] = '{-10, 5, -3, 6};
  localparam int BUMP_CY [4] = '{-10, 5, 4, 4};
  localparam longint BUMP_H [4] = '{12288, -6144, 4096, 8192};
  localparam longint unsigned BUMP_INV [4] = '{167772, 1864135, 1048576, 1048576};

  localparam longint unsigned NEG_EXP [65] = '{
    65536, 51039, 39750, 30957, 24109, 18776, 14623, 11388,
    8869, 6907, 5380, 4190, 3263, 2541, 1979, 1541,
    1200, 935, 728, 567, 442, 344, 268, 209,
    162, 127, 99, 77, 60, 47, 36, 28,
    22, 17, 13, 10, 8, 6, 5, 4,
    3, 2, 2, 1, 1, 1, 1, 1,
    0, 0, 0, 0, 0, 0, 0, 0,
    0, 0, 0, 0, 0, 0, 0, 0,
    0
  };

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    int unsigned gap;
    bit drain;
  } point_item_t;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [OUT_W-1:0] h;
  } height_due_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic signed [COORD_W-1:0] pos_x = '0;
  logic signed [COORD_W-1:0] pos_y = '0;
  logic busy;
  logic done;
  logic signed [OUT_W-1:0] height;

  point_item_t points_pending[$];
  height_due_t heights_due[$];
  point_item_t cur;
  height_due_t got_due;
  bit drive_on;
  bit gap_armed;
  int unsigned idle_left;
  int points_taken = 0;
  int heights_checked = 0;
  int errors = 0;

  gaussian_bump_height_sum_top #(.NUM_BUMPS(NB)) u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .pos_x(pos_x),
    .pos_y(pos_y),
    .done(done),
    .height(height)
  );

  function automatic logic signed [OUT_W-1:0] bump_height_sum(
    input logic signed [COORD_W-1:0] x,
    input logic signed [COORD_W-1:0] y
  );
    longint dx, dy, acc, r, e;
    longint unsigned d2, t, k, f, hi, lo;
    acc = 0;
    for (int i = 0; i < NB; i++) begin
      dx = longint'(x) - longint'(BUMP_CX[i]) * 256;
      dy = longint'(y) - longint'(BUMP_CY[i]) * 256;
      d2 = longint'(dx * dx) + longint'(dy * dy);
      t = (d2 * BUMP_INV[i]) >> 24;
      if (t >= (64'd16 << 16)) begin
        e = 0;
      end else begin
        k = t >> 14;
        f = t & 64'h3FFF;
        hi = NEG_EXP[k];
        lo = NEG_EXP[k + 1];
        e = longint'(hi - ((((hi - lo) * f) + 64'd8192) >> 14));
      end
      acc = acc + BUMP_H[i] * e;
    end
    r = (acc + 32768) >>> 16;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[OUT_W-1:0];
  endfunction

  function automatic int unsigned draw_gap(input bit calm);
    int unsigned roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [COORD_W-1:0] clip_coord(input int v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[COORD_W-1:0];
  endfunction

  task automatic add_point(input int x, input int y, input bit calm, input bit drain);
    point_item_t it;
    it.x = clip_coord(x);
    it.y = clip_coord(y);
    it.gap = draw_gap(calm);
    it.drain = drain;
    points_pending.insert(points_pending.size(), it);
  endtask

  task automatic fill_points();
    int b;
    bit calm;
    add_point(-32768, -32768, 1'b0, 1'b0);
    add_point(32767, 32767, 1'b0, 1'b0);
    add_point(-32768, 32767, 1'b0, 1'b0);
    add_point(32767, -32768, 1'b0, 1'b0);
    add_point(0, 0, 1'b0, 1'b0);
    add_point(-1, -1, 1'b0, 1'b0);
    for (int i = 0; i < 4; i++) begin
      add_point(BUMP_CX[i] * 256, BUMP_CY[i] * 256, 1'b0, 1'b0);
      add_point(BUMP_CX[i] * 256 + 1, BUMP_CY[i] * 256 - 1, 1'b1, 1'b0);
    end
    // The third bump reaches its cutoff exactly sixteen units from its center.
    add_point(-3 * 256 + 4096, 4 * 256, 1'b1, 1'b0);
    add_point(-3 * 256 + 4095, 4 * 256, 1'b1, 1'b0);
    add_point(-3 * 256, 4 * 256 - 4096, 1'b0, 1'b0);
    add_point(20000, -20000, 1'b0, 1'b0);
    add_point(-20000, 20000, 1'b0, 1'b1);
    add_point(6 * 256 + 128, 4 * 256 + 64, 1'b0, 1'b0);
    add_point(5 * 256 + 512, 5 * 256 - 512, 1'b0, 1'b0);
    add_point(-10 * 256 + 2560, -10 * 256 - 2560, 1'b0, 1'b0);
    add_point(2 * 256, 4 * 256, 1'b0, 1'b0);
    calm = 1'b0;
    for (int n = 0; n < RANDOM_POINTS; n++) begin
      if (n % 100 == 0) calm = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 9) < 4) begin
        add_point($urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768,
                  calm, (n % 250) == 125);
      end else begin
        b = $urandom_range(0, 3);
        add_point(BUMP_CX[b] * 256 + $urandom_range(0, 8191) - 4096,
                  BUMP_CY[b] * 256 + $urandom_range(0, 8191) - 4096,
                  calm, (n % 250) == 125);
      end
    end
  endtask

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      pos_x <= '0;
      pos_y <= '0;
      idle_left = 0;
      gap_armed = 1'b0;
    end else begin
      drive_on = start;
      if (start && !busy) begin
        heights_due.insert(heights_due.size(),
                           height_due_t'{x: pos_x, y: pos_y, h: bump_height_sum(pos_x, pos_y)});
        points_taken++;
        drive_on = 1'b0;
      end
      if (!drive_on && points_pending.size() > 0) begin
        if (!gap_armed) begin
          idle_left = points_pending[0].gap;
          gap_armed = 1'b1;
        end
        if (idle_left > 0) begin
          idle_left--;
        end else if (!(points_pending[0].drain && heights_due.size() > 0)) begin
          cur = points_pending.pop_front();
          pos_x <= cur.x;
          pos_y <= cur.y;
          drive_on = 1'b1;
          gap_armed = 1'b0;
        end
      end
      start <= drive_on;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      heights_checked++;
      if (heights_due.size() == 0) begin
        $display("%0t: height with no point waiting: expected none, got %0d", $time, height);
        errors++;
      end else begin
        got_due = heights_due.pop_front();
        if (height !== got_due.h) begin
          $display("%0t: height at (%0d, %0d): expected %0d, got %0d",
                   $time, got_due.x, got_due.y, got_due.h, height);
          errors++;
        end
      end
    end
  end

  initial begin
    fill_points();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    wait (points_pending.size() == 0 && !start);
    wait (heights_due.size() == 0);
    repeat (3 * PIPE_DEPTH) @(posedge clk);
    if (heights_due.size() != 0) begin
      $display("%0t: %0d heights never arrived", $time, heights_due.size());
      errors++;
    end
    $display("Checked %0d heights for %0d points: field corners, bump centers,",
             heights_checked, points_taken);
    $display("the cutoff edge, points far from every bump and random points near them.");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d points unsent and %0d heights outstanding.",
             points_pending.size(), heights_due.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
